>>> design/spq_pkg.sv
// Shared types, codes and microcode ROM for the sorted priority queue.
// Used by spq_mem, spq_seq, spq_dp, sorted_priority_queue_top and the bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned ENTRY_W     = 2 * DATA_W;
	localparam int unsigned COUNT_OUT_W = 7;

	localparam logic [1:0] ACT_INSERT  = 2'd0;
	localparam logic [1:0] ACT_EXTRACT = 2'd1;
	localparam logic [1:0] ACT_MODIFY  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_NOTFND = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE      = 5'd0,
		S_INS_CHK   = 5'd1,
		S_INS_RD    = 5'd2,
		S_INS_CMP   = 5'd3,
		S_INS_MOV   = 5'd4,
		S_INS_PUT   = 5'd5,
		S_FULL      = 5'd6,
		S_EXT_CHK   = 5'd7,
		S_EXT_RD    = 5'd8,
		S_EXT_TAKE  = 5'd9,
		S_EMPTY     = 5'd10,
		S_MOD_CHK   = 5'd11,
		S_MOD_RD    = 5'd12,
		S_MOD_CMP   = 5'd13,
		S_REM_RD    = 5'd14,
		S_REM_MOV   = 5'd15,
		S_REM_END   = 5'd16,
		S_FRONT_RD  = 5'd17,
		S_FRONT_CAP = 5'd18,
		S_NOTFND    = 5'd19
	} step_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_DISPATCH,
		C_FULL,
		C_EMPTY,
		C_IDX_NEG,
		C_IDX_END,
		C_NO_SHIFT,
		C_NO_MATCH,
		C_IS_MOD,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_CNT_M1,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_MOVE_UP,   // mem[idx+1] <= read data
		WR_MOVE_DN,   // mem[idx-1] <= read data
		WR_NEW        // mem[idx+1] <= latched item
	} wr_op_t;

	typedef struct packed {
		cond_t   cond;
		step_t   target;
		logic    accept;
		idx_op_t idx_op;
		cnt_op_t cnt_op;
		logic    rd_zero;
		wr_op_t  wr_op;
		logic    st_set;
		status_t st_code;
		logic    take;
		logic    load_out;
	} ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic idx_neg;
		logic idx_end;
		logic no_shift;
		logic no_match;
		logic is_mod;
	} flags_t;

	localparam ctrl_t CTRL_NOP = '{
		cond:     C_NEVER,
		target:   S_IDLE,
		accept:   1'b0,
		idx_op:   IDX_HOLD,
		cnt_op:   CNT_HOLD,
		rd_zero:  1'b0,
		wr_op:    WR_NONE,
		st_set:   1'b0,
		st_code:  ST_OK,
		take:     1'b0,
		load_out: 1'b0
	};

	// Microcode: one control word per step; a jump goes to target when cond holds,
	// otherwise the step counter advances by one; the idle step instead dispatches on the action.
	function automatic ctrl_t rom(input step_t s);
		ctrl_t w;
		w = CTRL_NOP;
		case (s)
			S_IDLE: begin
				w.cond = C_DISPATCH; w.accept = 1'b1;
			end
			S_INS_CHK: begin
				w.cond = C_FULL; w.target = S_FULL; w.idx_op = IDX_CNT_M1;
			end
			S_INS_RD: begin
				w.cond = C_IDX_NEG; w.target = S_INS_PUT;
			end
			S_INS_CMP: begin
				w.cond = C_NO_SHIFT; w.target = S_INS_PUT;
			end
			S_INS_MOV: begin
				w.cond = C_ALWAYS; w.target = S_INS_RD;
				w.wr_op = WR_MOVE_UP; w.idx_op = IDX_DEC;
			end
			S_INS_PUT: begin
				w.cond = C_ALWAYS; w.target = S_FRONT_RD;
				w.wr_op = WR_NEW; w.cnt_op = CNT_INC;
			end
			S_FULL: begin
				w.cond = C_ALWAYS; w.target = S_FRONT_RD;
				w.st_set = 1'b1; w.st_code = ST_FULL;
			end
			S_EXT_CHK: begin
				w.cond = C_EMPTY; w.target = S_EMPTY; w.idx_op = IDX_ZERO;
			end
			S_EXT_RD: begin
				w.cond = C_NEVER;
			end
			S_EXT_TAKE: begin
				w.cond = C_ALWAYS; w.target = S_REM_RD;
				w.take = 1'b1; w.idx_op = IDX_INC;
			end
			S_EMPTY: begin
				w.cond = C_ALWAYS; w.target = S_FRONT_RD;
				w.st_set = 1'b1; w.st_code = ST_EMPTY;
			end
			S_MOD_CHK: begin
				w.cond = C_NEVER; w.idx_op = IDX_ZERO;
			end
			S_MOD_RD: begin
				w.cond = C_IDX_END; w.target = S_NOTFND;
			end
			S_MOD_CMP: begin
				// idx steps past the hit too, which is where removal starts
				w.cond = C_NO_MATCH; w.target = S_MOD_RD; w.idx_op = IDX_INC;
			end
			S_REM_RD: begin
				w.cond = C_IDX_END; w.target = S_REM_END;
			end
			S_REM_MOV: begin
				w.cond = C_ALWAYS; w.target = S_REM_RD;
				w.wr_op = WR_MOVE_DN; w.idx_op = IDX_INC;
			end
			S_REM_END: begin
				w.cond = C_IS_MOD; w.target = S_INS_CHK; w.cnt_op = CNT_DEC;
			end
			S_FRONT_RD: begin
				w.cond = C_OUT_BUSY; w.target = S_FRONT_RD; w.rd_zero = 1'b1;
			end
			S_FRONT_CAP: begin
				w.cond = C_ALWAYS; w.target = S_IDLE; w.load_out = 1'b1;
			end
			S_NOTFND: begin
				w.cond = C_ALWAYS; w.target = S_FRONT_RD;
				w.st_set = 1'b1; w.st_code = ST_NOTFND;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> design/spq_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on spq_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module spq_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [spq_pkg::ENTRY_W-1:0] wr_data,
	input  wire logic [AW-1:0]               rd_addr,
	output      logic [spq_pkg::ENTRY_W-1:0] rd_data
);

	logic [spq_pkg::ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> design/spq_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on spq_pkg for step codes, control word and flag types.
`timescale 1ns / 1ps
`default_nettype none

module spq_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [1:0]       action,
	input  wire logic             out_busy,
	input  wire spq_pkg::flags_t  flags,
	output      spq_pkg::ctrl_t   ctrl
);

	spq_pkg::step_t step_q, step_d, step_inc, dispatch;
	logic           take_jump;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= spq_pkg::S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// control word
	always_comb begin
		ctrl = spq_pkg::rom(step_q);
	end

	// next step
	always_comb begin
		step_inc = spq_pkg::step_t'(step_q + 5'd1);
		case (action)
			spq_pkg::ACT_INSERT:  dispatch = spq_pkg::S_INS_CHK;
			spq_pkg::ACT_EXTRACT: dispatch = spq_pkg::S_EXT_CHK;
			spq_pkg::ACT_MODIFY:  dispatch = spq_pkg::S_MOD_CHK;
			default:              dispatch = spq_pkg::S_FRONT_RD;
		endcase
		case (ctrl.cond)
			spq_pkg::C_ALWAYS:   take_jump = 1'b1;
			spq_pkg::C_FULL:     take_jump = flags.full;
			spq_pkg::C_EMPTY:    take_jump = flags.empty;
			spq_pkg::C_IDX_NEG:  take_jump = flags.idx_neg;
			spq_pkg::C_IDX_END:  take_jump = flags.idx_end;
			spq_pkg::C_NO_SHIFT: take_jump = flags.no_shift;
			spq_pkg::C_NO_MATCH: take_jump = flags.no_match;
			spq_pkg::C_IS_MOD:   take_jump = flags.is_mod;
			spq_pkg::C_OUT_BUSY: take_jump = out_busy;
			default:             take_jump = 1'b0;
		endcase
		if (ctrl.cond == spq_pkg::C_DISPATCH) begin
			step_d = in_valid ? dispatch : step_q;
		end else if (take_jump) begin
			step_d = ctrl.target;
		end else begin
			step_d = step_inc;
		end
	end

endmodule

`default_nettype wire

>>> design/spq_dp.sv
// Datapath: index and count registers, latched item, status and taken entry,
// and the entry store. Driven by the control word from spq_seq.
// Depends on spq_pkg and spq_mem.
`timescale 1ns / 1ps
`default_nettype none

module spq_dp #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned AW       = 6,
	parameter int unsigned IW       = 7,
	parameter int unsigned CW       = 7
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [1:0]                   action,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item_priority,
	input  wire spq_pkg::ctrl_t               ctrl,
	output      spq_pkg::flags_t              flags,
	output      spq_pkg::status_t             status,
	output      logic [spq_pkg::DATA_W-1:0]   taken_value,
	output      logic [spq_pkg::DATA_W-1:0]   taken_priority,
	output      logic [spq_pkg::DATA_W-1:0]   head_value,
	output      logic [spq_pkg::DATA_W-1:0]   head_priority,
	output      logic [CW-1:0]                count
);

	logic [IW-1:0]                idx_q;
	logic [CW-1:0]                count_q;
	logic [1:0]                   action_q;
	logic signed [spq_pkg::DATA_W-1:0] val_q, pri_q;
	spq_pkg::status_t             status_q;
	logic [spq_pkg::DATA_W-1:0]   taken_val_q, taken_pri_q;

	logic [spq_pkg::ENTRY_W-1:0]  rd_data, wr_data;
	logic [AW-1:0]                rd_addr, wr_addr;
	logic                         wr_en;
	logic signed [spq_pkg::DATA_W-1:0] rd_val, rd_pri;
	logic [IW-1:0]                idx_p1, idx_m1, count_ext;
	logic                         shift_ok;

	assign rd_val    = rd_data[spq_pkg::ENTRY_W-1:spq_pkg::DATA_W];
	assign rd_pri    = rd_data[spq_pkg::DATA_W-1:0];
	assign idx_p1    = idx_q + IW'(1);
	assign idx_m1    = idx_q - IW'(1);
	assign count_ext = IW'(count_q);

	// never pass a head entry of equal priority
	assign shift_ok = (idx_q == '0) ? (rd_pri < pri_q) : (rd_pri <= pri_q);

	always_comb begin
		flags.full     = (count_q == CW'(CAPACITY));
		flags.empty    = (count_q == '0);
		flags.idx_neg  = (idx_q == '1);
		flags.idx_end  = (idx_q >= count_ext);
		flags.no_shift = !shift_ok;
		flags.no_match = (rd_val != val_q);
		flags.is_mod   = (action_q == spq_pkg::ACT_MODIFY);
	end

	always_comb begin
		rd_addr = ctrl.rd_zero ? '0 : idx_q[AW-1:0];
		wr_en   = (ctrl.wr_op != spq_pkg::WR_NONE);
		case (ctrl.wr_op)
			spq_pkg::WR_MOVE_DN: wr_addr = idx_m1[AW-1:0];
			default:             wr_addr = idx_p1[AW-1:0];
		endcase
		case (ctrl.wr_op)
			spq_pkg::WR_NEW: wr_data = {val_q, pri_q};
			default:         wr_data = rd_data;
		endcase
	end

	spq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			case (ctrl.idx_op)
				spq_pkg::IDX_ZERO:   idx_q <= '0;
				spq_pkg::IDX_CNT_M1: idx_q <= count_ext - IW'(1);
				spq_pkg::IDX_INC:    idx_q <= idx_p1;
				spq_pkg::IDX_DEC:    idx_q <= idx_m1;
				default:             idx_q <= idx_q;
			endcase
			case (ctrl.cnt_op)
				spq_pkg::CNT_INC: count_q <= count_q + CW'(1);
				spq_pkg::CNT_DEC: count_q <= count_q - CW'(1);
				default:          count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= action;
			val_q       <= item_value;
			pri_q       <= item_priority;
			status_q    <= spq_pkg::ST_OK;
			taken_val_q <= '0;
			taken_pri_q <= '0;
		end else begin
			if (ctrl.st_set) begin
				status_q <= ctrl.st_code;
			end
			if (ctrl.take) begin
				taken_val_q <= rd_val;
				taken_pri_q <= rd_pri;
			end
		end
	end

	assign status         = status_q;
	assign taken_value    = taken_val_q;
	assign taken_priority = taken_pri_q;
	assign head_value     = rd_val;
	assign head_priority  = rd_pri;
	assign count          = count_q;

endmodule

`default_nettype wire

>>> design/sorted_priority_queue_top.sv
// Sorted priority queue: one item at a time. Modify scans the entries for the value,
// then removes the hit and inserts it as an insert would. The entry store allows
// one read and one write per step of the microcode.
// A result waits in the output register while the next item is accepted.
// Reset: queue empty, sequencer idle, no result pending; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic [1:0]                          action,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   item_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   item_priority,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [1:0]                          status,
	output      logic signed [spq_pkg::DATA_W-1:0]   taken_value,
	output      logic signed [spq_pkg::DATA_W-1:0]   taken_priority,
	output      logic signed [spq_pkg::DATA_W-1:0]   front_value,
	output      logic signed [spq_pkg::DATA_W-1:0]   front_priority,
	output      logic [spq_pkg::COUNT_OUT_W-1:0]     entry_count
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned IW = AW + 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	spq_pkg::ctrl_t             ctrl;
	spq_pkg::flags_t            flags;
	spq_pkg::status_t           dp_status;
	logic [spq_pkg::DATA_W-1:0] dp_taken_val, dp_taken_pri, dp_head_val, dp_head_pri;
	logic [CW-1:0]              dp_count;
	logic [CW+spq_pkg::COUNT_OUT_W-1:0] count_wide;
	logic                       accept, out_busy;

	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [spq_pkg::DATA_W-1:0] taken_val_q, taken_pri_q, front_val_q, front_pri_q;
	logic [spq_pkg::COUNT_OUT_W-1:0] count_q;

	assign in_ready   = ctrl.accept;
	assign accept     = in_valid && in_ready;
	assign out_busy   = out_valid_q && !out_ready;
	assign count_wide = {{spq_pkg::COUNT_OUT_W{1'b0}}, dp_count};

	spq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.out_busy (out_busy),
		.flags    (flags),
		.ctrl     (ctrl)
	);

	spq_dp #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.IW       (IW),
		.CW       (CW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.action         (action),
		.item_value     (item_value),
		.item_priority  (item_priority),
		.ctrl           (ctrl),
		.flags          (flags),
		.status         (dp_status),
		.taken_value    (dp_taken_val),
		.taken_priority (dp_taken_pri),
		.head_value     (dp_head_val),
		.head_priority  (dp_head_pri),
		.count          (dp_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// head read lands in the same step that loads the result register
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			status_q    <= dp_status;
			taken_val_q <= dp_taken_val;
			taken_pri_q <= dp_taken_pri;
			front_val_q <= (dp_count == '0) ? '0 : dp_head_val;
			front_pri_q <= (dp_count == '0) ? '0 : dp_head_pri;
			count_q     <= count_wide[spq_pkg::COUNT_OUT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign taken_value    = taken_val_q;
	assign taken_priority = taken_pri_q;
	assign front_value    = front_val_q;
	assign front_priority = front_pri_q;
	assign entry_count    = count_q;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for sorted_priority_queue_top: directed and random traffic with
// a behavioral model of the sorted queue that predicts every result.
// Depends on spq_pkg and the design top only.
`timescale 1ns / 1ps

module tb;

	localparam int QCAP = 64;
	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam int STUCK_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 700;

	typedef struct {
		logic [1:0] act;
		int         v;
		int         pr;
	} op_t;

	typedef struct {
		int val;
		int pri;
	} entry_t;

	typedef struct {
		spq_pkg::status_t st;
		int      tv;
		int      tp;
		int      fv;
		int      fp;
		int      cnt;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic signed [31:0] item_value;
	logic signed [31:0] item_priority;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic signed [31:0] taken_value;
	logic signed [31:0] taken_priority;
	logic signed [31:0] front_value;
	logic signed [31:0] front_priority;
	logic [6:0]  entry_count;

	op_t      pending_ops[$];
	outcome_t due_results[$];
	entry_t   held[$];
	int       used_values[$];
	int       value_pool[24];
	int       err_count = 0;
	int       ops_sent = 0;
	int       results_seen = 0;
	int       peak_depth = 0;
	int       status_hits[4] = '{0, 0, 0, 0};
	int       stuck = 0;

	sorted_priority_queue_top #(.CAPACITY(QCAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .item_value(item_value), .item_priority(item_priority),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .taken_value(taken_value), .taken_priority(taken_priority),
		.front_value(front_value), .front_priority(front_priority),
		.entry_count(entry_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- model of the sorted queue ----------------
	// new entry goes before the first entry of lower or equal priority,
	// but never ahead of a head entry of equal priority
	function automatic void place_entry(int v, int pr);
		int pos;
		if (held.size() == 0 || held[0].pri < pr)
			pos = 0;
		else begin
			pos = 1;
			while (pos < held.size() && held[pos].pri > pr)
				pos++;
		end
		held.insert(pos, '{val: v, pri: pr});
	endfunction

	function automatic outcome_t queue_op_outcome(logic [1:0] act, int v, int pr);
		outcome_t r;
		int hit;
		r.st = spq_pkg::ST_OK; r.tv = 0; r.tp = 0; r.fv = 0; r.fp = 0; r.cnt = 0;
		hit = -1;
		case (act)
			spq_pkg::ACT_INSERT: begin
				if (held.size() >= QCAP)
					r.st = spq_pkg::ST_FULL;
				else
					place_entry(v, pr);
			end
			spq_pkg::ACT_EXTRACT: begin
				if (held.size() == 0)
					r.st = spq_pkg::ST_EMPTY;
				else begin
					r.tv = held[0].val;
					r.tp = held[0].pri;
					held.delete(0);
				end
			end
			spq_pkg::ACT_MODIFY: begin
				for (int i = 0; i < held.size() && hit < 0; i++)
					if (held[i].val == v)
						hit = i;
				if (hit < 0)
					r.st = spq_pkg::ST_NOTFND;
				else begin
					held.delete(hit);
					place_entry(v, pr);
				end
			end
			default: ;
		endcase
		if (held.size() > 0) begin
			r.fv = held[0].val;
			r.fp = held[0].pri;
		end
		r.cnt = held.size();
		if (r.cnt > peak_depth)
			peak_depth = r.cnt;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic void add_op(logic [1:0] act, int v, int pr);
		pending_ops.push_back('{act: act, v: v, pr: pr});
		if (act == spq_pkg::ACT_INSERT) begin
			used_values.push_back(v);
			if (used_values.size() > 64)
				void'(used_values.pop_front());
		end
	endfunction

	function automatic int pick_value();
		if ($urandom_range(99) < 70)
			return value_pool[$urandom_range(23)];
		return $urandom;
	endfunction

	// small range gives lots of ties; extremes and full range cover sign handling
	function automatic int pick_priority();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $signed($urandom_range(6)) - 3;
		if (r < 85) begin
			case ($urandom_range(4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h8000_0001;
				3: return 32'h7fff_fffe;
				default: return 0;
			endcase
		end
		return $urandom;
	endfunction

	task automatic random_run(int n, int ins_pct, int ext_pct);
		int r;
		int v;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < ins_pct)
				add_op(spq_pkg::ACT_INSERT, pick_value(), pick_priority());
			else if (r < ins_pct + ext_pct)
				add_op(spq_pkg::ACT_EXTRACT, $urandom, $urandom);
			else if (r < 97) begin
				if (used_values.size() > 0 && $urandom_range(99) < 80)
					v = used_values[$urandom_range(used_values.size() - 1)];
				else
					v = pick_value();
				add_op(spq_pkg::ACT_MODIFY, v, pick_priority());
			end else
				add_op(ACT_NOP, $urandom, $urandom);
		end
	endtask

	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_valid || due_results.size() > 0)
			@(posedge clk);
	endtask

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		op_t nxt;
		bit  gap;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			action        <= spq_pkg::ACT_INSERT;
			item_value    <= '0;
			item_priority <= '0;
		end else begin
			if (in_valid && in_ready) begin
				due_results.push_back(queue_op_outcome(action, item_value, item_priority));
				ops_sent++;
			end
			// no idling while ops 300..419 go through
			gap = !(ops_sent >= 300 && ops_sent < 420) && ($urandom_range(99) < 8);
			if (!in_valid || in_ready) begin
				if (pending_ops.size() > 0 && !gap) begin
					nxt = pending_ops.pop_front();
					in_valid      <= 1'b1;
					action        <= nxt.act;
					item_value    <= nxt.v;
					item_priority <= nxt.pr;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	task automatic check_field(string name, int exp, logic [31:0] act);
		if (act !== exp) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
				$time, name, exp, exp, $signed(act), act);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					err_count++;
					$display("%0t: result transfer with nothing expected (status %0d, count %0d)",
						$time, status, entry_count);
				end else begin
					want = due_results.pop_front();
					status_hits[want.st]++;
					check_field("status", want.st, {30'd0, status});
					check_field("taken_value", want.tv, taken_value);
					check_field("taken_priority", want.tp, taken_priority);
					check_field("front_value", want.fv, front_value);
					check_field("front_priority", want.fp, front_priority);
					check_field("entry_count", want.cnt, {25'd0, entry_count});
				end
			end
			out_ready <= (results_seen >= 300 && results_seen < 420) ||
				($urandom_range(99) >= 8);
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(pending_ops.size() == 0 && !in_valid && due_results.size() == 0))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, STUCK_LIMIT, due_results.size());
			$display("tb: errors");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		for (int i = 0; i < 24; i++)
			value_pool[i] = (i < 12) ? i - 4 : $urandom;
		value_pool[20] = 32'h8000_0000;
		value_pool[21] = 32'h7fff_ffff;
		value_pool[22] = -1;

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty queue cases, extremes, ties at the head and tail
		add_op(spq_pkg::ACT_EXTRACT, 0, 0);
		add_op(spq_pkg::ACT_MODIFY, 7, 1);
		add_op(ACT_NOP, 32'hffff_ffff, 32'hffff_ffff);
		add_op(spq_pkg::ACT_INSERT, 32'h7fff_ffff, 0);
		add_op(spq_pkg::ACT_INSERT, 32'h8000_0000, 0);
		add_op(spq_pkg::ACT_INSERT, -1, 32'h7fff_ffff);
		add_op(spq_pkg::ACT_INSERT, 0, 32'h8000_0000);
		add_op(spq_pkg::ACT_INSERT, 5, 32'h7fff_ffff);
		add_op(spq_pkg::ACT_INSERT, 6, -1);
		add_op(spq_pkg::ACT_MODIFY, 32'h8000_0000, 32'h7fff_ffff);
		add_op(spq_pkg::ACT_MODIFY, 12345, 3);
		add_op(spq_pkg::ACT_MODIFY, 0, 0);
		add_op(ACT_NOP, 32'h5a5a_a5a5, 32'ha5a5_5a5a);
		add_op(spq_pkg::ACT_EXTRACT, 0, 0);
		add_op(spq_pkg::ACT_EXTRACT, 0, 0);
		add_op(spq_pkg::ACT_MODIFY, 32'h7fff_ffff, 32'h8000_0000);
		repeat (5)
			add_op(spq_pkg::ACT_EXTRACT, 32'hffff_ffff, 32'hffff_ffff);
		wait_drained();

		// fill past capacity, drain past empty, then mixed traffic
		random_run(150, 78, 9);
		random_run(130, 12, 75);
		wait_drained();
		random_run(200, 40, 35);
		random_run(90, 80, 8);
		random_run(80, 12, 75);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("tb: %0d operations and %0d results checked, queue depth reached %0d",
			ops_sent, results_seen, peak_depth);
		$display("tb: status ok %0d, empty %0d, full %0d, not found %0d",
			status_hits[spq_pkg::ST_OK], status_hits[spq_pkg::ST_EMPTY],
			status_hits[spq_pkg::ST_FULL], status_hits[spq_pkg::ST_NOTFND]);
		if (err_count == 0 && due_results.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> sorted_priority_queue_top.f
design/spq_pkg.sv
design/spq_mem.sv
design/spq_seq.sv
design/spq_dp.sv
design/sorted_priority_queue_top.sv
tb/tb.sv
